FILE: rtl/wavetable_oscillator_interp_defines.svh
// ----------------------------------------------------------------------------
// Wavetable oscillator: assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_INTERP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond holds at every edge out of reset
`define WTOSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define WTOSC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante in a cycle implies cons in the next cycle
`define WTOSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WTOSC_ASSERT_ALWAYS(label, cond, msg)
`define WTOSC_ASSERT_IMPLIES(label, ante, cons, msg)
`define WTOSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/wtosc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared constants, register map and pipeline control type.
// ----------------------------------------------------------------------------
package wtosc_pkg;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned IDX_IN_W = 12;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // output queue
  localparam int unsigned OQ_DEPTH = 16;
  localparam int unsigned OQ_PTR_W = 4;
  localparam int unsigned OQ_CNT_W = 5;

  localparam logic [PHASE_W-1:0] RST_PHASE_STEP   = 32'd39370533;
  localparam logic [PHASE_W-1:0] RST_PHASE_OFFSET = 32'd0;
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE    = 16'd16384;
  localparam logic [LEN_W-1:0]   RST_TABLE_LENGTH = 13'd1;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_PHASE_OFFSET = 2'd1,
    REG_AMPLITUDE    = 2'd2,
    REG_TABLE_LENGTH = 2'd3
  } reg_idx_e;

  // per-stage control of one pipeline slot
  typedef struct packed {
    logic render;  // render request in this slot
    logic load;    // in-range load request in this slot
    logic bend;    // last frame of the buffer
  } ctrl_t;

endpackage

FILE: rtl/wtosc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module wtosc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

FILE: rtl/wtosc_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase and index stages
// Frame times step, plus offset, times length: table index pair and fraction.
// ----------------------------------------------------------------------------
module wtosc_phase #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned AW           = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wtosc_pkg::ctrl_t            ctrl_i,
  input  logic [31:0]                 frame_i,
  input  logic [AW-1:0]               widx_i,
  input  logic [SAMPLE_WIDTH-1:0]     wval_i,
  input  logic [31:0]                 step_i,
  input  logic [31:0]                 offset_i,
  input  logic [12:0]                 len_i,
  output wtosc_pkg::ctrl_t            ctrl_o,
  output logic [12:0]                 i0_o,
  output logic [12:0]                 i1_o,
  output logic [15:0]                 frac_o,
  output logic [AW-1:0]               widx_o,
  output logic [SAMPLE_WIDTH-1:0]     wval_o
);
  import wtosc_pkg::*;

  ctrl_t                       ctrl1_q, ctrl2_q, ctrl3_q;
  logic [PHASE_W-1:0]          mul1_d, mul1_q;
  logic [PHASE_W-1:0]          phase2_q;
  logic [PHASE_W+LEN_W-1:0]    prod3_d, prod3_q;
  logic [AW-1:0]               widx1_q, widx2_q, widx3_q;
  logic [SAMPLE_WIDTH-1:0]     wval1_q, wval2_q, wval3_q;
  logic [LEN_W:0]              nxt;

  // low word only: the integer part of the phase is the wrap
  assign mul1_d  = PHASE_W'(frame_i * step_i);
  assign prod3_d = {{LEN_W{1'b0}}, phase2_q} * {{PHASE_W{1'b0}}, len_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul1_q   <= mul1_d;
    phase2_q <= mul1_q + offset_i;
    prod3_q  <= prod3_d;
    widx1_q  <= widx_i;
    widx2_q  <= widx1_q;
    widx3_q  <= widx2_q;
    wval1_q  <= wval_i;
    wval2_q  <= wval1_q;
    wval3_q  <= wval2_q;
  end

  assign i0_o   = prod3_q[PHASE_W+LEN_W-1:PHASE_W];
  assign frac_o = prod3_q[PHASE_W-1:PHASE_W-FRAC_W];
  assign nxt    = {1'b0, i0_o} + (LEN_W+1)'(1);
  assign i1_o   = (nxt >= {1'b0, len_i}) ? '0 : nxt[LEN_W-1:0];
  assign ctrl_o = ctrl3_q;
  assign widx_o = widx3_q;
  assign wval_o = wval3_q;

endmodule

FILE: rtl/wtosc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation and gain stages
// Linear blend of two words, amplitude scale, round half up, saturate.
// ----------------------------------------------------------------------------
module wtosc_interp #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wtosc_pkg::ctrl_t        ctrl_i,
  input  logic [15:0]             frac_i,
  input  logic [15:0]             amp_i,
  input  logic [SAMPLE_WIDTH-1:0] v0_i,
  input  logic [SAMPLE_WIDTH-1:0] v1_i,
  output logic                    res_vld_o,
  output logic [SAMPLE_WIDTH-1:0] res_sample_o,
  output logic                    res_sat_o,
  output logic                    res_bend_o
);
  import wtosc_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned ACC_W = SW + 18;
  localparam int unsigned P_W   = ACC_W + AMP_W + 1;
  localparam int unsigned R_W   = P_W - 31;

  logic                    vld4_q, vld5_q, vld6_q, vld7_q;
  logic                    bend4_q, bend5_q, bend6_q, bend7_q;
  logic [FRAC_W-1:0]       frac4_q;

  logic signed [SW:0]      diff;
  logic signed [FRAC_W:0]  frac_s;
  logic signed [ACC_W-1:0] prod_w, v0_ext, acc_d, acc_q;
  logic signed [AMP_W:0]   amp_s;
  logic signed [P_W-1:0]   p_d, p_q, sum_w;
  logic [R_W-1:0]          r_full;
  logic [R_W-SW:0]         r_top;
  logic                    ovf;
  logic [SW-1:0]           sample_d, sample_q;
  logic                    sat_q;

  // acc = v0 * 2^16 + (v1 - v0) * f, same as v0*(2^16-f) + v1*f
  always_comb begin
    diff   = {v1_i[SW-1], v1_i} - {v0_i[SW-1], v0_i};
    frac_s = {1'b0, frac4_q};
    prod_w = diff * frac_s;
    v0_ext = {{2{v0_i[SW-1]}}, v0_i, {FRAC_W{1'b0}}};
    acc_d  = v0_ext + prod_w;
  end

  always_comb begin
    amp_s = {1'b0, amp_i};
    p_d   = acc_q * amp_s;
  end

  always_comb begin
    sum_w  = p_q + P_W'(64'd1 << 30);
    r_full = sum_w[P_W-1:31];
    r_top  = r_full[R_W-1:SW-1];
    ovf    = !((&r_top) || (~|r_top));
    if (ovf) begin
      sample_d = r_full[R_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sample_d = r_full[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else begin
      vld4_q <= ctrl_i.render;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    frac4_q  <= frac_i;
    bend4_q  <= ctrl_i.bend;
    acc_q    <= acc_d;
    bend5_q  <= bend4_q;
    p_q      <= p_d;
    bend6_q  <= bend5_q;
    sample_q <= sample_d;
    sat_q    <= ovf;
    bend7_q  <= bend6_q;
  end

  assign res_vld_o    = vld7_q;
  assign res_sample_o = sample_q;
  assign res_sat_o    = sat_q;
  assign res_bend_o   = bend7_q;

endmodule

FILE: rtl/wtosc_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output queue
// Small register FIFO between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module wtosc_ofifo #(
  parameter int unsigned WIDTH = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  import wtosc_pkg::*;

  logic [WIDTH-1:0]    mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + OQ_CNT_W'(push_i) - OQ_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

FILE: rtl/wavetable_oscillator_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// A load request writes one signed word into the wave table; a render request
// carries an absolute frame count and returns one sample. The phase is
// frame * phase_step + phase_offset (Q0.32, wrapping), scaled by the table
// length into an index pair and a 16-bit fraction; the two words are blended,
// scaled by amplitude, rounded half up and saturated. One request is taken
// every cycle while in_stall_o is low. Render results are registered into
// the output queue; the queue is 16 deep and in_stall_o rises only while
// 16 render results are outstanding, so a full pipeline keeps streaming as
// long as results are taken. A load writes the table at the same stage where
// renders read it, so later renders always see it with no forwarding. The
// table needs no clearing pass: entries must be loaded before they are read.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_defines.svh"

module wavetable_oscillator_interp #(
  parameter int unsigned TABLE_DEPTH  = 4096,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtosc_pkg::PADDR_W-1:0] paddr,
  input  logic [wtosc_pkg::PDATA_W-1:0] pwdata,
  output logic [wtosc_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [11:0]                   table_index_i,
  input  logic [SAMPLE_WIDTH-1:0]       table_value_i,
  input  logic [31:0]                   frame_index_i,
  input  logic                          block_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]       sample_out_o,
  output logic                          saturated_o,
  output logic                          block_last_o
);
  import wtosc_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned RES_W = SAMPLE_WIDTH + 2;

  // --- configuration registers ---------------------------------------------
  logic [PHASE_W-1:0] phase_step_q, phase_offset_q;
  logic [AMP_W-1:0]   amplitude_q;
  logic [LEN_W-1:0]   table_length_q;
  logic [LEN_W-1:0]   len_eff_q, len_eff_d;  // clamped to 1..TABLE_DEPTH
  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic [LEN_W-1:0]   len_raw;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign len_raw = pwdata[LEN_W-1:0];

  always_comb begin
    priority if (len_raw == '0) begin
      len_eff_d = LEN_W'(1);
    end else if (32'(len_raw) > 32'(TABLE_DEPTH)) begin
      len_eff_d = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff_d = len_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= RST_PHASE_STEP;
      phase_offset_q <= RST_PHASE_OFFSET;
      amplitude_q    <= RST_AMPLITUDE;
      table_length_q <= RST_TABLE_LENGTH;
      len_eff_q      <= RST_TABLE_LENGTH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PHASE_STEP:   phase_step_q   <= pwdata;
        REG_PHASE_OFFSET: phase_offset_q <= pwdata;
        REG_AMPLITUDE:    amplitude_q    <= pwdata[AMP_W-1:0];
        REG_TABLE_LENGTH: begin
          table_length_q <= len_raw;
          len_eff_q      <= len_eff_d;
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PHASE_STEP:   prdata = phase_step_q;
      REG_PHASE_OFFSET: prdata = phase_offset_q;
      REG_AMPLITUDE:    prdata = PDATA_W'(amplitude_q);
      REG_TABLE_LENGTH: prdata = PDATA_W'(table_length_q);
    endcase
  end

  // --- request intake and result credits -----------------------------------
  // credit_q counts renders accepted whose results have not yet left; it
  // bounds the queue, so the queue can never overflow.
  logic                in_acc, render_acc, pop;
  logic [OQ_CNT_W-1:0] credit_q;
  ctrl_t               ctrl_in;

  assign in_stall_o = (credit_q == OQ_CNT_W'(OQ_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign render_acc = in_acc && func_i;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    ctrl_in.render = render_acc;
    ctrl_in.load   = in_acc && !func_i && (32'(table_index_i) < 32'(TABLE_DEPTH));
    ctrl_in.bend   = block_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + OQ_CNT_W'(render_acc) - OQ_CNT_W'(pop);
    end
  end

  // --- phase and index -----------------------------------------------------
  ctrl_t                   ctrl3;
  logic [LEN_W-1:0]        i0, i1;
  logic [FRAC_W-1:0]       frac3;
  logic [AW-1:0]           widx3;
  logic [SAMPLE_WIDTH-1:0] wval3;

  wtosc_phase #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_in),
    .frame_i  (frame_index_i),
    .widx_i   (AW'(table_index_i)),
    .wval_i   (table_value_i),
    .step_i   (phase_step_q),
    .offset_i (phase_offset_q),
    .len_i    (len_eff_q),
    .ctrl_o   (ctrl3),
    .i0_o     (i0),
    .i1_o     (i1),
    .frac_o   (frac3),
    .widx_o   (widx3),
    .wval_o   (wval3)
  );

  // --- wave table: loads write, renders read two entries, same stage -------
  logic [SAMPLE_WIDTH-1:0] v0, v1;

  wtosc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_wave_store (
    .clk_i     (clk_i),
    .we_i      (ctrl3.load),
    .waddr_i   (widx3),
    .wdata_i   (wval3),
    .ra_addr_i (AW'(i0)),
    .ra_data_o (v0),
    .rb_addr_i (AW'(i1)),
    .rb_data_o (v1)
  );

  // --- interpolation, gain, saturation -------------------------------------
  logic                    res_vld, res_sat, res_bend;
  logic [SAMPLE_WIDTH-1:0] res_sample;

  wtosc_interp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl3),
    .frac_i       (frac3),
    .amp_i        (amplitude_q),
    .v0_i         (v0),
    .v1_i         (v1),
    .res_vld_o    (res_vld),
    .res_sample_o (res_sample),
    .res_sat_o    (res_sat),
    .res_bend_o   (res_bend)
  );

  // --- output queue --------------------------------------------------------
  logic [RES_W-1:0] q_rdata;

  wtosc_ofifo #(
    .WIDTH (RES_W)
  ) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld),
    .wdata_i ({res_bend, res_sat, res_sample}),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .rdata_o (q_rdata)
  );

  assign sample_out_o = q_rdata[SAMPLE_WIDTH-1:0];
  assign saturated_o  = q_rdata[SAMPLE_WIDTH];
  assign block_last_o = q_rdata[SAMPLE_WIDTH+1];

  // --- checks ---------------------------------------------------------------
  `WTOSC_ASSERT_ALWAYS(a_credit_bound, credit_q <= OQ_CNT_W'(OQ_DEPTH), "credit overrun")
  `WTOSC_ASSERT_IMPLIES(a_out_has_credit, out_valid_o, credit_q != '0, "result without credit")
  `WTOSC_ASSERT_IMPLIES(a_pipe_has_credit, res_vld, credit_q != '0, "pipeline result untracked")
  `WTOSC_ASSERT_NEXT(a_stall_release, in_stall_o && pop, !in_stall_o, "stall stuck after pop")

endmodule
